// ----- hw/rtl/afr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package afr_pkg;

	// Field widths fixed by the frame format
	localparam int BYTE_W      = 8;
	localparam int ADDR_W      = 16;
	localparam int FLEN_W      = 6;
	localparam int POS_W       = 5;
	localparam int CFG_IDX_W   = 8;

	// Default buffer size in payload bytes
	localparam int MAX_PAYLOAD_DEF = 32;

	// Register map
	localparam logic [CFG_IDX_W-1:0] REG_HEAD = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TAIL = CFG_IDX_W'(1);

	// Register reset values
	localparam logic [BYTE_W-1:0] HEAD_RESET = 8'hAA;
	localparam logic [BYTE_W-1:0] TAIL_RESET = 8'h55;

endpackage
`default_nettype wire

// ----- hw/rtl/afr_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Received byte channel
interface afr_rx_if import afr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_data;

	modport source (output valid, output rx_data, input ready);
	modport sink   (input valid, input rx_data, output ready);
endinterface

// Payload result channel
interface afr_frame_if import afr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] source_address;
	logic [FLEN_W-1:0] frame_length;
	logic [POS_W-1:0]  byte_position;
	logic [BYTE_W-1:0] payload_byte;
	logic              last_of_frame;

	modport source (output valid, output source_address, output frame_length,
		output byte_position, output payload_byte, output last_of_frame, input ready);
	modport sink   (input valid, input source_address, input frame_length,
		input byte_position, input payload_byte, input last_of_frame, output ready);
endinterface

// Register write channel
interface afr_cfg_if import afr_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] addr;
	logic [BYTE_W-1:0]    data;

	modport source (output valid, output addr, output data, input ready);
	modport sink   (input valid, input addr, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/addressed_frame_receiver_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Addressed frame receiver: deframes head / address (LE16) / length / payload / tail.
// Channels:
//   rx    - one received byte per beat (valid/ready).
//   frame - one payload byte per beat with address, length, position and a
//           last flag on the final byte of the frame.
//   cfg   - register writes: index 0 head marker, index 1 tail marker.
//           Writes are always taken.
// Throughput: rx takes one byte per cycle while parsing. After a tail byte that
// matches, the payload drains from the buffer one byte at a time: the single-read
// interlock on the buffer's registered read port allows no new read while one is
// pending; rx is held off until the last buffer read is issued.
// The tail beat sets busy; the first result then passes the read and output registers.
// Reset: parser returns to head hunt, markers go to 0xAA / 0x55, output empties.
// The payload buffer is not cleared; only bytes of the current frame are read.
// Stall: a held result keeps the drain paused; the output register frees the
// buffer read for the next byte as soon as the current beat is taken.
module addressed_frame_receiver_top import afr_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	afr_rx_if.sink      rx,
	afr_frame_if.source frame,
	afr_cfg_if.sink     cfg
);

	localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
	localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	localparam logic [2:0] PH_HEAD   = 3'd0;
	localparam logic [2:0] PH_ADDR_L = 3'd1;
	localparam logic [2:0] PH_ADDR_H = 3'd2;
	localparam logic [2:0] PH_LEN    = 3'd3;
	localparam logic [2:0] PH_DATA   = 3'd4;
	localparam logic [2:0] PH_TAIL   = 3'd5;

	logic [BYTE_W-1:0] head_q;
	logic [BYTE_W-1:0] tail_q;

	logic [2:0]        phase_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  fill_q;
	logic [LEN_W-1:0]  fill_next;

	logic              accept;
	logic              drain_busy;
	logic              wr_en;
	logic              start;
	logic              len_bad;

	// Register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= HEAD_RESET;
			tail_q <= TAIL_RESET;
		end else if (cfg.valid) begin
			if (cfg.addr == REG_HEAD) begin
				head_q <= cfg.data;
			end else if (cfg.addr == REG_TAIL) begin
				tail_q <= cfg.data;
			end
		end
	end

	// Hold off input while the drain is still reading the buffer
	assign rx.ready  = !drain_busy;
	assign accept    = rx.valid && !drain_busy;
	assign fill_next = fill_q + LEN_W'(1);
	assign len_bad   = (rx.rx_data == '0) || (rx.rx_data > BYTE_W'(MAX_PAYLOAD));
	assign wr_en     = accept && (phase_q == PH_DATA);
	assign start     = accept && (phase_q == PH_TAIL) && (rx.rx_data == tail_q);

	// Frame parser
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEAD;
			addr_q  <= '0;
			len_q   <= '0;
			fill_q  <= '0;
		end else if (accept) begin
			unique case (phase_q)
				PH_HEAD: begin
					if (rx.rx_data == head_q) begin
						phase_q <= PH_ADDR_L;
						addr_q  <= '0;
						len_q   <= '0;
						fill_q  <= '0;
					end
				end
				PH_ADDR_L: begin
					addr_q  <= {{(ADDR_W-BYTE_W){1'b0}}, rx.rx_data};
					phase_q <= PH_ADDR_H;
				end
				PH_ADDR_H: begin
					addr_q  <= {rx.rx_data, addr_q[BYTE_W-1:0]};
					phase_q <= PH_LEN;
				end
				PH_LEN: begin
					fill_q <= '0;
					if (len_bad) begin
						phase_q <= PH_HEAD;
						addr_q  <= '0;
						len_q   <= '0;
					end else begin
						len_q   <= LEN_W'(rx.rx_data);
						phase_q <= PH_DATA;
					end
				end
				PH_DATA: begin
					fill_q <= fill_next;
					if (fill_next >= len_q) begin
						phase_q <= PH_TAIL;
					end
				end
				default: begin
					// Tail slot or unused code: back to the hunt
					phase_q <= PH_HEAD;
					addr_q  <= '0;
					len_q   <= '0;
					fill_q  <= '0;
				end
			endcase
		end
	end

	afr_drain #(
		.MAX_PAYLOAD(MAX_PAYLOAD),
		.LEN_W      (LEN_W),
		.IDX_W      (IDX_W)
	) u_drain (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_idx    (fill_q[IDX_W-1:0]),
		.wr_data   (rx.rx_data),
		.start     (start),
		.start_addr(addr_q),
		.start_len (len_q),
		.busy      (drain_busy),
		.frame     (frame)
	);

endmodule
`default_nettype wire

// ----- hw/rtl/afr_drain.sv -----
`timescale 1ns / 1ps
`default_nettype none
module afr_drain import afr_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
	parameter int LEN_W = $clog2(MAX_PAYLOAD + 1),
	parameter int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [IDX_W-1:0]  wr_idx,
	input  wire logic [BYTE_W-1:0] wr_data,
	input  wire logic              start,
	input  wire logic [ADDR_W-1:0] start_addr,
	input  wire logic [LEN_W-1:0]  start_len,
	output logic                   busy,
	afr_frame_if.source            frame
);

	logic [BYTE_W-1:0] mem [MAX_PAYLOAD];

	logic              busy_q;
	logic [LEN_W-1:0]  rd_cnt_q;
	logic [LEN_W-1:0]  len_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LEN_W-1:0]  rd_next;
	logic              issue;

	logic              pend_s1;
	logic [LEN_W-1:0]  pos_s1;
	logic              last_s1;
	logic [BYTE_W-1:0] rd_data_s1;

	logic              out_valid_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [FLEN_W-1:0] out_len_q;
	logic [POS_W-1:0]  out_pos_q;
	logic [BYTE_W-1:0] out_data_q;
	logic              out_last_q;

	// Issue one read at a time, only when the output register is free next cycle
	assign rd_next = rd_cnt_q + LEN_W'(1);
	assign issue   = busy_q && !pend_s1 && (!out_valid_q || frame.ready);
	assign busy    = busy_q;

	// Payload buffer: write from the parser, registered read for the drain
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (issue) begin
			rd_data_s1 <= mem[rd_cnt_q[IDX_W-1:0]];
		end
	end

	// Drain sequencer: step through the buffer once per accepted frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			rd_cnt_q <= '0;
			len_q    <= '0;
			addr_q   <= '0;
			pend_s1  <= 1'b0;
			pos_s1   <= '0;
			last_s1  <= 1'b0;
		end else begin
			pend_s1 <= issue;
			if (start) begin
				busy_q   <= 1'b1;
				rd_cnt_q <= '0;
				len_q    <= start_len;
				addr_q   <= start_addr;
			end else if (issue) begin
				pos_s1   <= rd_cnt_q;
				last_s1  <= (rd_next == len_q);
				rd_cnt_q <= rd_next;
				if (rd_next == len_q) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Output register: load read data, drop the beat once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pend_s1) begin
			out_valid_q <= 1'b1;
		end else if (frame.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_s1) begin
			out_addr_q <= addr_q;
			out_len_q  <= FLEN_W'(len_q);
			out_pos_q  <= POS_W'(pos_s1);
			out_data_q <= rd_data_s1;
			out_last_q <= last_s1;
		end
	end

	assign frame.valid          = out_valid_q;
	assign frame.source_address = out_addr_q;
	assign frame.frame_length   = out_len_q;
	assign frame.byte_position  = out_pos_q;
	assign frame.payload_byte   = out_data_q;
	assign frame.last_of_frame  = out_last_q;

endmodule
`default_nettype wire
